### sv/ptw_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the four-level page table walker.
// No dependencies.
package ptw_pkg;

  localparam int TABLE_POOL_DEF    = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int ENTRY_W           = 38;
  localparam int ADDR_W            = 48;

  localparam int ENT_PRESENT_BIT = 37;
  localparam int ENT_LEAF_BIT    = 36;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;
  localparam logic [1:0] OP_RSVD      = 2'd3;  // decodes as translate

  localparam logic [1:0] SZ_4K  = 2'd0;
  localparam logic [1:0] SZ_2M  = 2'd1;
  localparam logic [1:0] SZ_1G  = 2'd2;
  localparam logic [1:0] SZ_BAD = 2'd3;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_UNMAPPED   = 4'd1;  // plus walk depth
  localparam logic [3:0] ST_CONFLICT   = 4'd4;  // plus depth of conflict
  localparam logic [3:0] ST_MISALIGNED = 4'd8;
  localparam logic [3:0] ST_BAD_SIZE   = 4'd9;
  localparam logic [3:0] ST_POOL_FULL  = 4'd10;

endpackage

### sv/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// Four-level page table walker: sequencer around one table memory.
// Depends on ptw_pkg and ptw_ram.
//
// Holds a four-level radix translation structure in a memory of TABLE_POOL
// tables of 512 entries; table 0 is the root and further tables are handed
// out in order and never returned. After reset a clearing pass writes every
// entry with in_stall high. Each item then runs one at a time: an accept
// state, a read state and then a check state per level read from the table
// memory, on a map that allocates one S_ALLOC step per newly linked table
// plus one for the leaf, and a state to post the result, held there while
// the result register stays stalled. A finished result waits in the output
// register while the next word is taken.
module four_level_page_table_walker #(
  parameter int TABLE_POOL = ptw_pkg::TABLE_POOL_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [ptw_pkg::ADDR_W-1:0] in_guest_addr,
  input  logic [ptw_pkg::ADDR_W-1:0] in_host_addr,
  input  logic [1:0]                in_page_size,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_status,
  output logic [ptw_pkg::ADDR_W-1:0] out_result_addr,
  output logic [1:0]                out_leaf_level
);
  import ptw_pkg::*;

  localparam int DEPTH = TABLE_POOL * ENTRIES_PER_TABLE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW - IDX_W;
  localparam int NFW   = $clog2(TABLE_POOL + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_CHK   = 6'b001000,
    S_ALLOC = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [NFW-1:0]    next_free_r, next_free_nxt;
  logic [1:0]        op_r, op_nxt, sz_r, sz_nxt, d_r, d_nxt;
  logic [ADDR_W-1:0] gpa_r, gpa_nxt, hpa_r, hpa_nxt;
  logic [TW-1:0]     t_r, t_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [3:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [1:0]        res_lvl_r, res_lvl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [1:0]        out_lvl_r, out_lvl_nxt;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  logic [IDX_W-1:0]  idx_cur, idx_next;
  logic [1:0]        target;
  logic [1:0]        need;
  logic [NFW-1:0]    remaining;
  logic [TW-1:0]     nt;
  logic              misaligned;
  logic              e_present, e_leaf;
  logic [ENTRY_W-1:0] leaf_word;

  function automatic logic [IDX_W-1:0] level_idx(input logic [ADDR_W-1:0] a,
                                                 input logic [1:0] d);
    logic [IDX_W-1:0] r;
    case (d)
      2'd0:    r = a[47:39];
      2'd1:    r = a[38:30];
      2'd2:    r = a[29:21];
      default: r = a[20:12];
    endcase
    return r;
  endfunction

  ptw_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_cur   = level_idx(gpa_r, d_r);
  assign idx_next  = level_idx(gpa_r, d_r + 2'd1);
  assign target    = 2'd3 - sz_r;
  assign need      = target - d_r;
  assign remaining = NFW'(TABLE_POOL) - next_free_r;
  assign nt        = next_free_r[TW-1:0];
  assign e_present = rdata[ENT_PRESENT_BIT];
  assign e_leaf    = rdata[ENT_LEAF_BIT];
  assign leaf_word = {1'b1, 1'b1, hpa_r[47:12]};

  always_comb begin
    case (in_page_size)
      SZ_4K:   misaligned = |in_host_addr[11:0];
      SZ_2M:   misaligned = |in_host_addr[20:0];
      default: misaligned = |in_host_addr[29:0];
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    next_free_nxt  = next_free_r;
    op_nxt         = op_r;
    sz_nxt         = sz_r;
    d_nxt          = d_r;
    gpa_nxt        = gpa_r;
    hpa_nxt        = hpa_r;
    t_nxt          = t_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_lvl_nxt    = res_lvl_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_lvl_nxt    = out_lvl_r;
    we             = 1'b0;
    waddr          = slot_r;
    wdata          = '0;
    re             = 1'b0;
    raddr          = {t_r, idx_cur};
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          sz_nxt       = in_page_size;
          gpa_nxt      = in_guest_addr;
          hpa_nxt      = in_host_addr;
          d_nxt        = 2'd0;
          t_nxt        = '0;
          res_addr_nxt = '0;
          res_lvl_nxt  = 2'd0;
          state_nxt    = S_RD;
          if (in_op == OP_MAP && in_page_size == SZ_BAD) begin
            res_status_nxt = ST_BAD_SIZE;
            state_nxt      = S_DONE;
          end else if (in_op == OP_MAP && misaligned) begin
            res_status_nxt = ST_MISALIGNED;
            state_nxt      = S_DONE;
          end
        end
      end
      S_RD: begin
        re        = 1'b1;
        slot_nxt  = {t_r, idx_cur};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_DONE;
        if (op_r == OP_MAP) begin
          if (d_r == target) begin
            if (e_present) begin
              res_status_nxt = ST_CONFLICT + 4'(target);
            end else begin
              we             = 1'b1;
              wdata          = leaf_word;
              res_status_nxt = ST_OK;
              res_lvl_nxt    = sz_r;
            end
          end else if (!e_present) begin
            if (remaining < NFW'(need)) begin
              res_status_nxt = ST_POOL_FULL;
            end else begin
              state_nxt = S_ALLOC;
            end
          end else if (d_r != 2'd0 && e_leaf) begin
            res_status_nxt = ST_CONFLICT + 4'(d_r);
          end else begin
            t_nxt     = rdata[TW-1:0];
            d_nxt     = d_r + 2'd1;
            state_nxt = S_RD;
          end
        end else begin
          if (!e_present) begin
            res_status_nxt = ST_UNMAPPED + 4'(d_r);
          end else if (d_r == 2'd3 || (d_r != 2'd0 && e_leaf)) begin
            res_status_nxt = ST_OK;
            res_lvl_nxt    = ~d_r;
            if (op_r == OP_UNMAP) begin
              we = 1'b1;  // clear the leaf
            end else begin
              case (d_r)
                2'd1:    res_addr_nxt = {rdata[35:18], gpa_r[29:0]};
                2'd2:    res_addr_nxt = {rdata[35:9], gpa_r[20:0]};
                default: res_addr_nxt = {rdata[35:0], gpa_r[11:0]};
              endcase
            end
          end else begin
            t_nxt     = rdata[TW-1:0];
            d_nxt     = d_r + 2'd1;
            state_nxt = S_RD;
          end
        end
      end
      S_ALLOC: begin
        we = 1'b1;
        if (d_r == target) begin
          wdata          = leaf_word;
          res_status_nxt = ST_OK;
          res_lvl_nxt    = sz_r;
          state_nxt      = S_DONE;
        end else begin
          // link a fresh table and step into it
          wdata         = {1'b1, 1'b0, 36'(nt)};
          slot_nxt      = {nt, idx_next};
          d_nxt         = d_r + 2'd1;
          next_free_nxt = next_free_r + NFW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = (res_status_r == ST_OK) ? res_addr_r : '0;
          out_lvl_nxt    = (res_status_r == ST_OK) ? res_lvl_r : 2'd0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      next_free_r <= NFW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sz_r         <= sz_nxt;
    d_r          <= d_nxt;
    gpa_r        <= gpa_nxt;
    hpa_r        <= hpa_nxt;
    t_r          <= t_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_lvl_r    <= res_lvl_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_lvl_r    <= out_lvl_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_addr_r;
  assign out_leaf_level  = out_lvl_r;

endmodule

### sv/ptw_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ptw_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
